FILE: src/prce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prce_pkg
// Shared types, constants and the colour expansion function for the palette
// RAM colour expander.
// ----------------------------------------------------------------------------
package prce_pkg;

  localparam int unsigned PaletteBytesDef = 8192;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;
  localparam logic [1:0] SizeLong = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE
  } prce_state_e;

  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic commit;
  } prce_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_empty;
  } prce_sts_t;

  typedef struct packed {
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        color_valid;
    logic [11:0] color_entry;
    rgb_t        rgb;
    logic        last;
  } prce_res_t;

  function automatic rgb_t expand_color(input logic [15:0] w);
    rgb_t c;
    c.red   = {w[3:0],  w[12]};
    c.green = {w[7:4],  w[13]};
    c.blue  = {w[11:8], w[14]};
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/prce_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prce_ctrl
// Controller: clearing pass after reset, input acceptance and commit of the
// read-modify-write once the result buffer is empty.
// ----------------------------------------------------------------------------
module prce_ctrl
  import prce_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire prce_sts_t sts_i,
  output prce_cmd_t      cmd_o
);

  prce_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.rd_en = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (sts_i.out_empty) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/prce_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prce_datapath
// Two 16-bit banks (even and odd colour entries), byte merge, colour
// expansion and a two-deep result buffer.
// ----------------------------------------------------------------------------
module prce_datapath
  import prce_pkg::*;
#(
  parameter int unsigned PALETTE_BYTES = PaletteBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire prce_cmd_t   cmd_i,
  output prce_sts_t        sts_o,
  input  wire logic        op_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [12:0] byte_addr_i,
  input  wire logic [31:0] write_data_i,
  output prce_res_t        res_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  localparam int unsigned AW   = $clog2(PALETTE_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned Rows = PALETTE_BYTES / 4;

  logic [15:0] bank_even [Rows];
  logic [15:0] bank_odd  [Rows];

  logic [AW+12:0] addr_ext;
  logic [AW-1:0]  addr_in;
  logic [AW-1:0]  addr_q;
  logic           op_q;
  logic [1:0]     size_q;
  logic [31:0]    data_q;
  logic [15:0]    rd_even_q, rd_odd_q;
  logic [RW-1:0]  clr_q;

  assign addr_ext = {{AW{1'b0}}, byte_addr_i};
  assign addr_in  = addr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      op_q   <= op_i;
      size_q <= access_size_i;
      addr_q <= addr_in;
      data_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + RW'(1);
    end
  end

  logic          is_long, bank_sel, lane;
  logic [RW-1:0] row_q;
  logic [15:0]   old_sel, new_sel, new_even, new_odd;
  logic          we_even, we_odd;
  logic [RW-1:0] wr_row;
  logic [15:0]   wd_even, wd_odd;

  assign is_long  = size_q[1];
  assign row_q    = addr_q[AW-1:2];
  assign bank_sel = addr_q[1] & ~is_long;
  assign lane     = addr_q[0];
  assign old_sel  = bank_sel ? rd_odd_q : rd_even_q;

  always_comb begin
    priority if (is_long) begin
      new_sel = data_q[15:0];
    end else if (size_q == SizeWord) begin
      new_sel = data_q[15:0];
    end else if (lane) begin
      new_sel = {old_sel[15:8], data_q[7:0]};
    end else begin
      new_sel = {data_q[7:0], old_sel[7:0]};
    end
  end

  assign new_even = is_long ? data_q[31:16] : new_sel;
  assign new_odd  = is_long ? data_q[15:0]  : new_sel;

  assign we_even = cmd_i.clr_en
                 | (cmd_i.commit & (op_q == OpWrite) & (is_long | ~bank_sel));
  assign we_odd  = cmd_i.clr_en
                 | (cmd_i.commit & (op_q == OpWrite) & (is_long | bank_sel));
  assign wr_row  = cmd_i.clr_en ? clr_q : row_q;
  assign wd_even = cmd_i.clr_en ? 16'h0000 : new_even;
  assign wd_odd  = cmd_i.clr_en ? 16'h0000 : new_odd;

  always_ff @(posedge clk_i) begin
    if (we_even) begin
      bank_even[wr_row] <= wd_even;
    end
    if (cmd_i.rd_en) begin
      rd_even_q <= bank_even[addr_in[AW-1:2]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      bank_odd[wr_row] <= wd_odd;
    end
    if (cmd_i.rd_en) begin
      rd_odd_q <= bank_odd[addr_in[AW-1:2]];
    end
  end

  logic [31:0]   rd_word;
  logic [AW+10:0] ent0_ext, ent1_ext;
  prce_res_t     res_a, res_b;

  always_comb begin
    priority if (is_long) begin
      rd_word = {rd_even_q, rd_odd_q};
    end else if (size_q == SizeWord) begin
      rd_word = {16'h0000, old_sel};
    end else if (lane) begin
      rd_word = {24'h000000, old_sel[7:0]};
    end else begin
      rd_word = {24'h000000, old_sel[15:8]};
    end
  end

  assign ent0_ext = {12'h000, row_q, bank_sel};
  assign ent1_ext = {12'h000, row_q, 1'b1};

  always_comb begin
    res_a = '0;
    res_b = '0;
    if (op_q == OpRead) begin
      res_a.read_data = rd_word;
      res_a.last      = 1'b1;
    end else begin
      res_a.color_valid = 1'b1;
      res_a.color_entry = ent0_ext[11:0];
      res_a.rgb         = expand_color(is_long ? new_even : new_sel);
      res_a.last        = ~is_long;
      res_b.color_valid = 1'b1;
      res_b.color_entry = ent1_ext[11:0];
      res_b.rgb         = expand_color(new_odd);
      res_b.last        = 1'b1;
    end
  end

  prce_res_t  res0_q, res1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (cmd_i.commit) begin
      cnt_q <= ((op_q == OpWrite) && is_long) ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res0_q <= res_a;
      res1_q <= res_b;
    end else if (pop) begin
      res0_q <= res1_q;
    end
  end

  assign res_o           = res0_q;
  assign sts_o.out_empty = (cnt_q == 2'd0);
  assign sts_o.clr_last  = &clr_q;

endmodule
`default_nettype wire

FILE: src/palette_ram_color_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_ram_color_expand
// Byte-addressed palette RAM with big-endian byte/word/long access and xBGR
// colour expansion on every write.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all PALETTE_BYTES/4 rows
// (2048 at the default size) with in_ready_o low. PALETTE_BYTES must be a
// power of two. Each transaction has two steps: both 16-bit banks are read
// when it is accepted, then it is merged, written back and loaded into the
// result buffer. A read or a byte or word write gives one result, a long
// write two (lower entry first); a new transaction is taken while earlier
// results drain, and commits once the result buffer is empty. On a long
// write the second colour result holds off the next commit until it has
// been taken.
module palette_ram_color_expand
  import prce_pkg::*;
#(
  parameter int unsigned PALETTE_BYTES = PaletteBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [12:0] byte_addr_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             color_valid_o,
  output logic [11:0]      color_entry_o,
  output logic [4:0]       red_o,
  output logic [4:0]       green_o,
  output logic [4:0]       blue_o,
  output logic             last_o
);

  prce_cmd_t cmd;
  prce_sts_t sts;
  prce_res_t res;

  prce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prce_datapath #(
    .PALETTE_BYTES (PALETTE_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .access_size_i (access_size_i),
    .byte_addr_i   (byte_addr_i),
    .write_data_i  (write_data_i),
    .res_o         (res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  assign read_data_o   = res.read_data;
  assign color_valid_o = res.color_valid;
  assign color_entry_o = res.color_entry;
  assign red_o         = res.rgb.red;
  assign green_o       = res.rgb.green;
  assign blue_o        = res.rgb.blue;
  assign last_o        = res.last;

  a_commit_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_empty)
    else $error("commit with results pending");

  a_ready_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after accept");

  a_clear_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_second_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("second colour result missing");

endmodule
`default_nettype wire
